>>> hdl/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants
// Item formats, region codes and the widths of the divider and root chains.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int CoordW  = 16;                 // coordinate width
  localparam int FracB   = 8;                  // fraction bits of the distance
  localparam int DistW   = 25;                 // distance field width
  localparam int DiffW   = CoordW + 1;         // coordinate differences
  localparam int SqW     = 2 * DiffW - 1;      // sum of two squares (< 2^33)
  localparam int DenW    = SqW;                // divisor width
  localparam int CrossW  = SqW;                // cross product magnitude
  localparam int NumSqW  = 2 * CrossW;         // squared numerator before scaling
  localparam int NumW    = NumSqW + 2 * FracB; // scaled numerator
  localparam int QuotW   = 50;                 // quotient bits, one divider cell each
  localparam int RootW   = QuotW / 2;          // root bits, one root cell each
  localparam int RremW   = RootW + 2;          // root remainder
  localparam int FrontLat = 6;                 // register stages ahead of the divider
  localparam int Latency = FrontLat + QuotW + RootW;

  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_FIRST    = 2'd1,
    REGION_SECOND   = 2'd2,
    REGION_DEGEN    = 2'd3
  } region_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [1:0]       nearest_region;
  } out_item_t;

  // Token handed along the divider chain.
  typedef struct packed {
    logic              valid;
    region_t           region;
    logic [DenW-1:0]   rem;
    logic [QuotW-1:0]  num_low;
    logic [DenW-1:0]   den;
    logic [QuotW-1:0]  quot;
  } div_tok_t;

  // Token handed along the root chain.
  typedef struct packed {
    logic              valid;
    region_t           region;
    logic [RremW-1:0]  rem;
    logic [QuotW-1:0]  rad;
    logic [RootW-1:0]  root;
  } sqrt_tok_t;

endpackage

>>> hdl/psd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_front: geometry front end
// Differences, products, region choice and the squared numerator, in six
// register stages, feeding the first divider cell.
// ----------------------------------------------------------------------------
module psd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  psd_pkg::in_item_t  in_item,
  output psd_pkg::div_tok_t  tok_out
);

  localparam int DW = psd_pkg::DiffW;
  localparam int PW = 2 * DW;
  localparam int SW = psd_pkg::SqW;
  localparam int CH = SW - SW / 2;
  localparam int CL = SW / 2;

  logic [5:0] vld_r;

  // Stage A: differences.
  logic signed [DW-1:0] dx_r, dy_r, vx_r, vy_r, fx_r, fy_r;
  // Stage B: products.
  logic signed [PW-1:0] pdd_x_r, pdd_y_r, pff_x_r, pff_y_r, pvv_x_r, pvv_y_r;
  logic signed [PW-1:0] pdv_x_r, pdv_y_r, pc_a_r, pc_b_r;
  // Stage C: sums.
  logic [SW-1:0]        sd_r, sf_r, len2_r;
  logic signed [SW+1:0] t_r, cross_r;
  // Stage D: region and selection.
  psd_pkg::region_t     reg_d_r, reg_e_r, reg_f_r;
  logic [SW-1:0]        s_d_r, s_e_r, den_d_r, den_e_r;
  logic [SW-1:0]        c_d_r;
  // Stage E: partial products of the cross term square.
  logic [2*CH-1:0]      chh_r;
  logic [CH+CL-1:0]     chl_r;
  logic [2*CL-1:0]      cll_r;
  // Stage F: numerator.
  logic [psd_pkg::NumSqW-1:0] numsq_r;
  logic [SW-1:0]              den_f_r;

  logic signed [DW-1:0] px, py, sx, sy, ex, ey;
  logic signed [SW+1:0] t_nxt, cross_nxt;
  psd_pkg::region_t     reg_nxt;
  logic [SW-1:0]        cmag;
  logic [psd_pkg::NumSqW-1:0] numsq_nxt;
  logic [psd_pkg::NumW-1:0]   num_full;

  assign px = DW'(in_item.point_x);
  assign py = DW'(in_item.point_y);
  assign sx = DW'(in_item.start_x);
  assign sy = DW'(in_item.start_y);
  assign ex = DW'(in_item.end_x);
  assign ey = DW'(in_item.end_y);

  assign t_nxt     = (SW+2)'(pdv_x_r) + (SW+2)'(pdv_y_r);
  assign cross_nxt = (SW+2)'(pc_a_r) - (SW+2)'(pc_b_r);

  always_comb begin
    priority if (len2_r == '0) begin
      reg_nxt = psd_pkg::REGION_DEGEN;
    end else if (t_r <= 0) begin
      reg_nxt = psd_pkg::REGION_FIRST;
    end else if (t_r >= $signed({2'b00, len2_r})) begin
      reg_nxt = psd_pkg::REGION_SECOND;
    end else begin
      reg_nxt = psd_pkg::REGION_INTERIOR;
    end
  end

  assign cmag = cross_r[SW+1] ? SW'(-cross_r) : SW'(cross_r);

  always_comb begin
    if (reg_e_r == psd_pkg::REGION_INTERIOR) begin
      numsq_nxt = psd_pkg::NumSqW'({chh_r, {(2*CL){1'b0}}})
                + psd_pkg::NumSqW'({chl_r, {(CL+1){1'b0}}})
                + psd_pkg::NumSqW'(cll_r);
    end else begin
      numsq_nxt = psd_pkg::NumSqW'(s_e_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= px - sx;
    dy_r <= py - sy;
    vx_r <= ex - sx;
    vy_r <= ey - sy;
    fx_r <= px - ex;
    fy_r <= py - ey;

    pdd_x_r <= dx_r * dx_r;
    pdd_y_r <= dy_r * dy_r;
    pff_x_r <= fx_r * fx_r;
    pff_y_r <= fy_r * fy_r;
    pvv_x_r <= vx_r * vx_r;
    pvv_y_r <= vy_r * vy_r;
    pdv_x_r <= dx_r * vx_r;
    pdv_y_r <= dy_r * vy_r;
    pc_a_r  <= dx_r * vy_r;
    pc_b_r  <= dy_r * vx_r;

    sd_r    <= SW'(pdd_x_r) + SW'(pdd_y_r);
    sf_r    <= SW'(pff_x_r) + SW'(pff_y_r);
    len2_r  <= SW'(pvv_x_r) + SW'(pvv_y_r);
    t_r     <= t_nxt;
    cross_r <= cross_nxt;

    reg_d_r <= reg_nxt;
    s_d_r   <= (reg_nxt == psd_pkg::REGION_SECOND) ? sf_r : sd_r;
    den_d_r <= (reg_nxt == psd_pkg::REGION_INTERIOR) ? len2_r : SW'(1);
    c_d_r   <= cmag;

    reg_e_r <= reg_d_r;
    s_e_r   <= s_d_r;
    den_e_r <= den_d_r;
    chh_r   <= c_d_r[SW-1:CL] * c_d_r[SW-1:CL];
    chl_r   <= c_d_r[SW-1:CL] * c_d_r[CL-1:0];
    cll_r   <= c_d_r[CL-1:0] * c_d_r[CL-1:0];

    reg_f_r <= reg_e_r;
    den_f_r <= den_e_r;
    numsq_r <= numsq_nxt;
  end

  // The quotient is known to fit QuotW bits, so the bits above them start
  // out as the remainder and are already below the divisor.
  assign num_full = {numsq_r, {(2*psd_pkg::FracB){1'b0}}};

  always_comb begin
    tok_out.valid   = vld_r[5];
    tok_out.region  = reg_f_r;
    tok_out.rem     = psd_pkg::DenW'(num_full[psd_pkg::NumW-1:psd_pkg::QuotW]);
    tok_out.num_low = num_full[psd_pkg::QuotW-1:0];
    tok_out.den     = den_f_r;
    tok_out.quot    = '0;
  end

endmodule

>>> hdl/psd_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div_cell: one restoring division step
// Brings down one numerator bit, tries the divisor, records a quotient bit.
// ----------------------------------------------------------------------------
module psd_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  psd_pkg::div_tok_t  tok_in,
  output psd_pkg::div_tok_t  tok_out
);

  localparam int DW = psd_pkg::DenW;

  psd_pkg::div_tok_t tok_r, tok_nxt;
  logic [DW:0]       rem2;
  logic              fits;

  assign rem2 = {tok_in.rem, tok_in.num_low[psd_pkg::QuotW-1]};
  assign fits = rem2 >= {1'b0, tok_in.den};

  always_comb begin
    tok_nxt         = tok_in;
    tok_nxt.rem     = fits ? DW'(rem2 - {1'b0, tok_in.den}) : DW'(rem2);
    tok_nxt.num_low = {tok_in.num_low[psd_pkg::QuotW-2:0], 1'b0};
    tok_nxt.quot    = {tok_in.quot[psd_pkg::QuotW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> hdl/psd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_sqrt_cell: one digit-by-digit square root step
// Brings down two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module psd_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  psd_pkg::sqrt_tok_t  tok_in,
  output psd_pkg::sqrt_tok_t  tok_out
);

  localparam int RW = psd_pkg::RremW;

  psd_pkg::sqrt_tok_t tok_r, tok_nxt;
  logic [RW+1:0]      rem4;
  logic [RW+1:0]      trial;
  logic               fits;

  assign rem4  = {tok_in.rem, tok_in.rad[psd_pkg::QuotW-1 -: 2]};
  assign trial = (RW+2)'({tok_in.root, 2'b01});
  assign fits  = rem4 >= trial;

  always_comb begin
    tok_nxt      = tok_in;
    tok_nxt.rem  = fits ? RW'(rem4 - trial) : RW'(rem4);
    tok_nxt.rad  = {tok_in.rad[psd_pkg::QuotW-3:0], 2'b00};
    tok_nxt.root = {tok_in.root[psd_pkg::RootW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> hdl/point_segment_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance: distance from a point to a line segment
// The pipeline is six front stages, fifty divider cells and 25 root cells.
// Throughput is one transfer per cycle; busy is never raised and the result
// strobe cannot be held off by the receiver.
// Reset (synchronous, active low) clears every valid bit in the chains;
// anything in flight is dropped.
// ----------------------------------------------------------------------------
// The front end forms d = point - start, e = end - start, the projection
// t = d.e, the squared length L = e.e and the cross product d x e. From these
// it picks the nearest part of the segment and builds a quotient problem:
// for either end the squared distance over one, for the interior the squared
// cross product over L, both scaled by two to the power of twice the fraction
// bits. A chain of restoring division cells then yields the floor of that
// quotient one bit per cell, and a chain of root cells takes its integer
// square root two radicand bits per cell. Since r*r <= floor(N/D) exactly when
// r*r*D <= N, the result is the truncated distance.
// ----------------------------------------------------------------------------
module point_segment_distance (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psd_pkg::in_item_t   in_item,
  output logic                out_valid,
  output psd_pkg::out_item_t  out_item
);

  localparam int NQ = psd_pkg::QuotW;
  localparam int NR = psd_pkg::RootW;

  psd_pkg::div_tok_t  div_tok  [NQ+1];
  psd_pkg::sqrt_tok_t sqrt_tok [NR+1];

  // Every cycle can take a transfer: the chains move on unconditionally.
  assign busy = 1'b0;

  psd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start),
    .in_item (in_item),
    .tok_out (div_tok[0])
  );

  for (genvar i = 0; i < NQ; i++) begin : g_div
    psd_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (div_tok[i]),
      .tok_out(div_tok[i+1])
    );
  end

  // The quotient becomes the radicand of the root chain.
  always_comb begin
    sqrt_tok[0].valid  = div_tok[NQ].valid;
    sqrt_tok[0].region = div_tok[NQ].region;
    sqrt_tok[0].rem    = '0;
    sqrt_tok[0].rad    = div_tok[NQ].quot;
    sqrt_tok[0].root   = '0;
  end

  for (genvar j = 0; j < NR; j++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (sqrt_tok[j]),
      .tok_out(sqrt_tok[j+1])
    );
  end

  // The last root cell is the output register.
  assign out_valid               = sqrt_tok[NR].valid;
  assign out_item.distance       = psd_pkg::DistW'(sqrt_tok[NR].root);
  assign out_item.nearest_region = sqrt_tok[NR].region;

endmodule

>>> hdl/psd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker: port-level checks
// Fixed latency, no stalls and the degenerate-segment flag, seen at the ports.
// ----------------------------------------------------------------------------
module psd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  psd_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  psd_pkg::out_item_t  out_item
);

  localparam int Lat = psd_pkg::Latency;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##Lat out_valid) else $error("transfer produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, Lat)) else $error("result without a transfer");

  a_degen_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_item.nearest_region == psd_pkg::REGION_DEGEN) ==
       ($past(in_item.start_x, Lat) == $past(in_item.end_x, Lat) &&
        $past(in_item.start_y, Lat) == $past(in_item.end_y, Lat))))
    else $error("degenerate segment flag wrong");

endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);
